/* rtl/cnd_pkg.sv */
// shared constants, widths and fixed-point helpers for the diffusion step block
package cnd_pkg;

    // grid size and derived widths
    localparam int POINTS   = 128;
    localparam int PT_AW    = $clog2(POINTS);
    localparam int IDX_W    = 7;
    localparam int VW       = 32;
    localparam int GW       = 31;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 32;
    localparam int OPW      = 34;
    localparam int PMW      = 2 * OPW;
    localparam int DNW      = 41;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_RATIO = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_WALL  = 1'b1;

    // reset values and saturation limits
    localparam logic [GW-1:0]        RATIO_RST = 31'd16777216;
    localparam logic signed [VW-1:0] WALL_RST  = 32'sd16777216;
    localparam logic signed [47:0]   ONE_Q     = 48'sd16777216;
    localparam logic signed [47:0]   MAX32     = 48'sd2147483647;
    localparam logic signed [47:0]   MIN32     = -48'sd2147483648;

    // magnitude of a signed multiplier operand
    function automatic logic [OPW-1:0] mag_op(input logic signed [OPW-1:0] x);
        logic [OPW-1:0] m;
        m = x[OPW-1] ? OPW'(-x) : OPW'(x);
        return m;
    endfunction

    // q8.24 rounding of a product magnitude, ties away from zero
    function automatic logic signed [47:0] rnd_q(input logic [PMW-1:0] m, input logic neg);
        logic [PMW-1:0] r;
        logic [47:0]    t;
        r = (m + PMW'(8388608)) >> 24;
        t = r[47:0];
        return neg ? -$signed(t) : $signed(t);
    endfunction

    // saturate to signed 32 bits
    function automatic logic signed [VW-1:0] sat32(input logic signed [47:0] x);
        logic signed [VW-1:0] r;
        if (x > MAX32) begin
            r = MAX32[VW-1:0];
        end else if (x < MIN32) begin
            r = MIN32[VW-1:0];
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/cnd_if.sv */
// valid/ready channel interfaces for command items and result items
interface cnd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [cnd_pkg::IDX_W-1:0]  point_index;

    modport source (output valid, kind, point_index, input ready);
    modport sink   (input valid, kind, point_index, output ready);
endinterface

interface cnd_out_if;
    logic                           valid;
    logic                           ready;
    logic [cnd_pkg::IDX_W-1:0]      read_index;
    logic signed [cnd_pkg::VW-1:0]  velocity;

    modport source (output valid, read_index, velocity, input ready);
    modport sink   (input valid, read_index, velocity, output ready);
endinterface

/* rtl/cnd_ram.sv */
// generic single-port-write, registered-read memory
module cnd_ram #(
    parameter int AW = 7,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/cnd_div.sv */
// serial restoring divider giving a rounded, saturated q8.24 quotient
module cnd_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [cnd_pkg::DNW-1:0]   i_num,
    input  logic signed [cnd_pkg::DNW-1:0]   i_den,
    output logic                             o_done,
    output logic signed [cnd_pkg::VW-1:0]    o_quo
);
    import cnd_pkg::*;

    logic                  r_busy, r_fin, r_done;
    logic [5:0]            r_cnt;
    logic [DNW:0]          r_rem;
    logic [31:0]           r_low, r_q;
    logic [DNW-1:0]        r_md;
    logic                  r_neg, r_nneg, r_nz, r_zero, r_ovf;
    logic signed [VW-1:0]  r_quo;

    logic [DNW-1:0]        w_mn, w_md;
    logic [65:0]           w_n;
    logic [DNW+1:0]        w_t, w_sub;
    logic                  w_ge;
    logic signed [VW-1:0]  w_res;

    // operand setup
    always_comb begin
        w_mn = i_num[DNW-1] ? DNW'(-i_num) : DNW'(i_num);
        w_md = i_den[DNW-1] ? DNW'(-i_den) : DNW'(i_den);
        w_n  = {1'b0, w_mn, 24'b0} + 66'(w_md >> 1);
    end

    // one quotient bit per cycle
    always_comb begin
        w_t   = {r_rem, r_low[31]};
        w_ge  = w_t >= {2'b0, r_md};
        w_sub = w_t - {2'b0, r_md};
    end

    // final sign and saturation
    always_comb begin
        if (r_zero) begin
            w_res = !r_nz ? '0 : (r_nneg ? MIN32[VW-1:0] : MAX32[VW-1:0]);
        end else if (r_ovf || r_q[31]) begin
            w_res = r_neg ? MIN32[VW-1:0] : MAX32[VW-1:0];
        end else begin
            w_res = r_neg ? -$signed(r_q) : $signed(r_q);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_md   <= w_md;
            r_rem  <= (DNW+1)'(w_n[65:32]);
            r_low  <= w_n[31:0];
            r_q    <= '0;
            r_neg  <= i_num[DNW-1] != i_den[DNW-1];
            r_nneg <= i_num[DNW-1];
            r_nz   <= w_mn != '0;
            r_zero <= w_md == '0;
            r_ovf  <= {7'b0, w_n} >= {w_md, 32'b0};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DNW:0] : w_t[DNW:0];
            r_low <= {r_low[30:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
        end
        if (r_fin) begin
            r_quo <= w_res;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* rtl/crank_nicolson_diffusion_step.sv */
// Crank-Nicolson diffusion step: 1-D velocity profile between a still bottom wall
// and a moving top wall, advanced by a forward and a backward Thomas sweep.
// Points 1..POINTS-2 live in a registered-read memory, the Thomas ratio and term
// in a second one; point 0 is always 0 and the top point is the wall register.
// A read item registers its result through S_RD once no earlier result is still
// waiting. An advance item runs a forward sweep over each interior point (the read
// state, the shared-multiplier states S_FM0 to S_FM4, a start state and a wait for
// the two serial dividers running side by side for ratio and term), then a backward
// sweep of read, multiply and write states per point. An advance item gives no
// result; a read item gives one.
module crank_nicolson_diffusion_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cnd_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  logic [cnd_pkg::CFG_DW-1:0]       i_cfg_data,
    cnd_in_if.sink                           i_in,
    cnd_out_if.source                        o_out
);
    import cnd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_FIN  = 4'd2;
    localparam logic [3:0] S_FRD  = 4'd3;
    localparam logic [3:0] S_FM0  = 4'd4;
    localparam logic [3:0] S_FM1  = 4'd5;
    localparam logic [3:0] S_FM2  = 4'd6;
    localparam logic [3:0] S_FM3  = 4'd7;
    localparam logic [3:0] S_FM4  = 4'd8;
    localparam logic [3:0] S_FDS  = 4'd9;
    localparam logic [3:0] S_FDW  = 4'd10;
    localparam logic [3:0] S_BRD  = 4'd11;
    localparam logic [3:0] S_BM   = 4'd12;
    localparam logic [3:0] S_BW   = 4'd13;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_MEM  = 2'd1;
    localparam logic [1:0] SEL_WALL = 2'd2;

    localparam logic [PT_AW-1:0] TOP  = PT_AW'(POINTS - 1);
    localparam logic [PT_AW-1:0] LAST = PT_AW'(POINTS - 2);
    localparam logic [PT_AW-1:0] ONE  = PT_AW'(1);

    logic [3:0]             r_state;
    logic [GW-1:0]          r_ratio;
    logic signed [VW-1:0]   r_wall;
    logic [PT_AW-1:0]       r_j;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_vvalid [POINTS];
    logic [1:0]             r_vsel;
    logic                   r_rvalid;
    logic signed [VW-1:0]   r_uprev, r_ucur, r_unext, r_uup;
    logic signed [VW-1:0]   r_pprev, r_qprev, r_d;
    logic signed [47:0]     r_t;
    logic signed [DNW-1:0]  r_den, r_numq;
    logic [PMW-1:0]         r_pmag;
    logic                   r_pneg;
    logic                   r_ovalid;
    logic [IDX_W-1:0]       r_oidx;
    logic signed [VW-1:0]   r_ovel;

    logic                   w_vre, w_vwe, w_pqre, w_pqwe;
    logic [PT_AW-1:0]       w_vaddr;
    logic [VW-1:0]          w_vrdata;
    logic [2*VW-1:0]        w_pqrdata;
    logic signed [VW-1:0]   w_vread;
    logic signed [OPW-1:0]  w_ma, w_mb;
    logic signed [47:0]     w_pr, w_a, w_u48;
    logic signed [VW-1:0]   w_unew;
    logic signed [DNW-1:0]  w_nump;
    logic                   w_start, w_pdone, w_qdone;
    logic signed [VW-1:0]   w_pquo, w_qquo;
    logic                   w_rd_ok;

    // memories: interior velocities and thomas ratio/term pairs
    cnd_ram #(.AW(PT_AW), .DW(VW)) u_vmem (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (r_j),
        .i_wdata (w_unew),
        .i_re    (w_vre),
        .i_raddr (w_vaddr),
        .o_rdata (w_vrdata)
    );

    cnd_ram #(.AW(PT_AW), .DW(2 * VW)) u_pqmem (
        .i_clk   (i_clk),
        .i_we    (w_pqwe),
        .i_waddr (r_j),
        .i_wdata ({w_pquo, w_qquo}),
        .i_re    (w_pqre),
        .i_raddr (r_j),
        .o_rdata (w_pqrdata)
    );

    // dividers for ratio and term share the denominator
    cnd_div u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_nump),
        .i_den   (r_den),
        .o_done  (w_pdone),
        .o_quo   (w_pquo)
    );

    cnd_div u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_numq),
        .i_den   (r_den),
        .o_done  (w_qdone),
        .o_quo   (w_qquo)
    );

    // velocity read port control
    assign w_rd_ok = 32'(i_in.point_index) < 32'(POINTS);
    always_comb begin
        w_vre   = 1'b0;
        w_vaddr = r_j + ONE;
        if (r_state == S_IDLE && i_in.valid) begin
            w_vre   = 1'b1;
            w_vaddr = i_in.kind ? PT_AW'(i_in.point_index) : ONE;
        end else if (r_state == S_FRD) begin
            w_vre = 1'b1;
        end
    end

    // resolve a velocity read: bottom wall, top wall, stored or never written
    always_comb begin
        case (r_vsel)
            SEL_MEM:  w_vread = r_rvalid ? $signed(w_vrdata) : '0;
            SEL_WALL: w_vread = r_wall;
            default:  w_vread = '0;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        w_ma = $signed({{(OPW-GW+1){1'b0}}, r_ratio[GW-1:1]});
        w_mb = OPW'(r_pprev);
        case (r_state)
            S_FM0: begin
                w_ma = $signed({{(OPW-GW){1'b0}}, r_ratio}) - OPW'(ONE_Q);
                w_mb = OPW'(r_ucur);
            end
            S_FM1: w_mb = OPW'(r_unext) + OPW'(r_uprev);
            S_FM2: w_mb = OPW'(r_pprev);
            S_FM3: w_mb = OPW'(r_qprev);
            S_BM: begin
                w_ma = OPW'($signed(w_pqrdata[2*VW-1:VW]));
                w_mb = OPW'(r_uup);
            end
            default: w_mb = OPW'(r_pprev);
        endcase
    end

    // rounded product and derived terms
    assign w_pr    = rnd_q(r_pmag, r_pneg);
    assign w_a     = -(ONE_Q + $signed({17'b0, r_ratio}));
    assign w_nump  = -$signed({{(DNW-GW+1){1'b0}}, r_ratio[GW-1:1]});
    assign w_u48   = w_pr + 48'($signed(w_pqrdata[VW-1:0]));
    assign w_unew  = sat32(w_u48);
    assign w_start = r_state == S_FDS;
    assign w_vwe   = r_state == S_BW;
    assign w_pqwe  = r_state == S_FDW && w_pdone;
    assign w_pqre  = r_state == S_BRD;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RST;
            r_wall  <= WALL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATIO: r_ratio <= i_cfg_data[GW-1:0];
                CFG_WALL:  r_wall  <= $signed(i_cfg_data[VW-1:0]);
                default:   r_ratio <= r_ratio;
            endcase
        end
    end

    // valid bits of the velocity memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POINTS; k++) begin
                r_vvalid[k] <= 1'b0;
            end
        end else if (w_vwe) begin
            r_vvalid[r_j] <= 1'b1;
        end
    end

    // read tag registered with the memory data
    always_ff @(posedge i_clk) begin
        if (w_vre) begin
            r_rvalid <= r_vvalid[w_vaddr];
            if (r_state == S_IDLE && i_in.kind && !w_rd_ok) begin
                r_vsel <= SEL_ZERO;
            end else if (w_vaddr == '0) begin
                r_vsel <= SEL_ZERO;
            end else if (w_vaddr == TOP) begin
                r_vsel <= SEL_WALL;
            end else begin
                r_vsel <= SEL_MEM;
            end
        end
    end

    // multiplier stage
    always_ff @(posedge i_clk) begin
        r_pmag <= PMW'(mag_op(w_ma)) * PMW'(mag_op(w_mb));
        r_pneg <= w_ma[OPW-1] != w_mb[OPW-1];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // result register: load on a read item, clear when taken
            if (r_state == S_RD && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_idx   <= i_in.point_index;
                        r_state <= i_in.kind ? S_RD : S_FIN;
                    end
                end
                S_RD: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_oidx   <= r_idx;
                        r_ovel   <= w_vread;
                        r_state  <= S_IDLE;
                    end
                end
                S_FIN: begin
                    r_uprev <= '0;
                    r_ucur  <= w_vread;
                    r_pprev <= '0;
                    r_qprev <= '0;
                    r_j     <= ONE;
                    r_state <= S_FRD;
                end
                S_FRD: r_state <= S_FM0;
                S_FM0: begin
                    r_unext <= w_vread;
                    r_state <= S_FM1;
                end
                S_FM1: begin
                    r_t     <= w_pr;
                    r_state <= S_FM2;
                end
                S_FM2: begin
                    r_d     <= sat32(r_t - w_pr);
                    r_state <= S_FM3;
                end
                S_FM3: begin
                    r_den   <= DNW'(w_a + w_pr);
                    r_state <= S_FM4;
                end
                S_FM4: begin
                    r_numq  <= DNW'(48'(r_d) - w_pr);
                    r_state <= S_FDS;
                end
                S_FDS: r_state <= S_FDW;
                S_FDW: begin
                    if (w_pdone) begin
                        r_pprev <= w_pquo;
                        r_qprev <= w_qquo;
                        r_uprev <= r_ucur;
                        r_ucur  <= r_unext;
                        if (r_j == LAST) begin
                            r_uup   <= r_wall;
                            r_state <= S_BRD;
                        end else begin
                            r_j     <= r_j + ONE;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_BRD: r_state <= S_BM;
                S_BM:  r_state <= S_BW;
                S_BW: begin
                    r_uup <= w_unew;
                    if (r_j == ONE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j - ONE;
                        r_state <= S_BRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ports
    assign i_in.ready       = r_state == S_IDLE;
    assign o_out.valid      = r_ovalid;
    assign o_out.read_index = r_oidx;
    assign o_out.velocity   = r_ovel;

`ifndef SYNTH
    // a result only appears after a read item
    a_out_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_RD)
        else $error("result raised without a read item");

    // both dividers finish together
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pdone == w_qdone)
        else $error("divider lanes out of step");

    // forward point index stays interior
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FRD |-> r_j >= ONE && r_j <= LAST)
        else $error("forward sweep index out of range");

    // no new item during the backward sweep
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BW && r_j != ONE |=> !i_in.ready)
        else $error("item accepted during backward sweep");
`endif
endmodule
